@@ rtl/specular_free_pixel_assert.svh @@
// ----------------------------------------------------------------------------
// specular_free_pixel assertion macros
// Shared concurrent assertion forms for the pixel block checkers.
// ----------------------------------------------------------------------------
`ifndef SPECULAR_FREE_PIXEL_ASSERT_SVH
`define SPECULAR_FREE_PIXEL_ASSERT_SVH

// check outside reset
`define SPF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define SPF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/spf_pkg.sv @@
// ----------------------------------------------------------------------------
// spf_pkg
// Widths and constants shared by the specular-free pixel modules.
// ----------------------------------------------------------------------------
package spf_pkg;

   localparam int PIX_W      = 8;
   localparam int SUM_W      = 10;
   localparam int DCM_W      = 17;
   localparam int T1_W       = 19;
   localparam int THR_W      = 18;
   localparam int DIFF_SHIFT = 16;

   localparam logic [T1_W-1:0]  DCM_ONE  = T1_W'(65536);
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

   typedef logic [PIX_W-1:0] pix_type;

endpackage

@@ rtl/spf_div.sv @@
// ----------------------------------------------------------------------------
// spf_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module spf_div #(
   parameter int NUM_W  = 24,
   parameter int DEN_W  = 10,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              v_ff    [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  num_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              v_s;
      logic [DEN_W-1:0]  rem_s;
      logic [NUM_W-1:0]  num_s;
      logic [DEN_W-1:0]  den_s;
      logic [SIDE_W-1:0] side_s;
      logic [DEN_W:0]    part;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  num_in;

      if (k == 0) begin : g_first
         assign v_s    = in_valid;
         assign rem_s  = '0;
         assign num_s  = in_num;
         assign den_s  = in_den;
         assign side_s = in_side;
      end else begin : g_next
         assign v_s    = v_ff[k-1];
         assign rem_s  = rem_ff[k-1];
         assign num_s  = num_ff[k-1];
         assign den_s  = den_ff[k-1];
         assign side_s = side_ff[k-1];
      end

      always_comb begin
         part   = {rem_s, num_s[NUM_W-1]};
         ge     = part >= {1'b0, den_s};
         rem_in = ge ? DEN_W'(part - {1'b0, den_s}) : part[DEN_W-1:0];
         num_in = {num_s[NUM_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_s;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            num_ff[k]  <= num_in;
            den_ff[k]  <= den_s;
            side_ff[k] <= side_s;
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quo   = num_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

@@ rtl/spf_chan.sv @@
// ----------------------------------------------------------------------------
// spf_chan
// Subtract the specular term from one channel, clamp and round half up.
// ----------------------------------------------------------------------------
module spf_chan #(
   parameter int FRAC_W = 16
) (
   input  spf_pkg::pix_type          ch,
   input  logic signed [FRAC_W+10:0] spec,
   output spf_pkg::pix_type          ch_out
);
   import spf_pkg::*;

   localparam int V_W = FRAC_W + 12;
   localparam logic signed [V_W-1:0] TOP  = V_W'(255) << FRAC_W;
   localparam logic signed [V_W-1:0] HALF = V_W'(1) << (FRAC_W - 1);

   logic signed [V_W-1:0] v;
   logic signed [V_W-1:0] clamped;
   logic signed [V_W-1:0] rounded;

   always_comb begin
      v = $signed({4'b0, ch, FRAC_W'(0)}) - V_W'(spec);
      priority if (v < 0) begin
         clamped = '0;
      end else if (v > TOP) begin
         clamped = TOP;
      end else begin
         clamped = v;
      end
      rounded = clamped + HALF;
      ch_out  = rounded[FRAC_W +: PIX_W];
   end

endmodule

@@ rtl/specular_free_pixel.sv @@
// ----------------------------------------------------------------------------
// specular_free_pixel
// Removes the specular part of one RGB pixel, one pixel per clock unless the receiver stalls.
//
// Input channel req_*: red, green, blue and the pixel's maximum diffuse
// chromaticity (unsigned Q1.16), valid/ready. Result channel rsp_*: the
// corrected pixel, valid/ready. csr_wr_en/csr_wr_data write the zero
// threshold (Q.16); a pixel whose t0 falls below it passes unchanged.
// The two restoring dividers take one quotient bit per stage: the
// chromaticity divider CHROMA_FRAC_BITS+8 stages and the diffuse
// divider CHROMA_FRAC_BITS+26, plus six register stages around them.
// Throughput is one pixel per cycle while the receiver takes results.
// Reset empties the pipeline and sets the threshold to 1. When the
// receiver stalls with a result waiting, the whole pipeline holds and
// req_ready drops in the same cycle; no item is lost or repeated.
// ----------------------------------------------------------------------------
module specular_free_pixel #(
   parameter int CHROMA_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_red_in,
   input  logic [7:0]                 req_green_in,
   input  logic [7:0]                 req_blue_in,
   input  logic [16:0]                req_diffuse_chroma_max,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_red_out,
   output logic [7:0]                 rsp_green_out,
   output logic [7:0]                 rsp_blue_out,
   input  logic                       csr_wr_en,
   input  logic [17:0]                csr_wr_data
);
   import spf_pkg::*;

   localparam int F      = CHROMA_FRAC_BITS;
   localparam int N1_W   = PIX_W + F;
   localparam int C_W    = F + 1;
   localparam int P_W    = T1_W + C_W;
   localparam int T2_W   = F + 2;
   localparam int MT_W   = F + 10;
   localparam int N2_W   = MT_W + DIFF_SHIFT;
   localparam int A_W    = F + 10;
   localparam int K_W    = F + 11;
   localparam int S_W    = F + 12;
   localparam int Q_W    = A_W - 1;
   localparam int SPEC_W = F + 11;
   localparam int SIDE1_W = T1_W + PIX_W + 3 * PIX_W + SUM_W;
   localparam int SIDE2_W = 1 + 3 * PIX_W + SUM_W;

   localparam logic [S_W:0]   K_FULL = (((S_W + 1)'(1) << S_W) + (S_W + 1)'(2)) / 3;
   localparam logic [K_W-1:0] RECIP  = K_FULL[K_W-1:0];
   localparam logic [A_W-1:0] LIM    = ((A_W'(255) << F) + A_W'(1)) * A_W'(3);
   localparam logic [F+2:0]   ONE_F  = (F + 3)'(1) << F;

   logic en;

   logic [THR_W-1:0] thr_ff;

   // stage A
   logic             a_v_ff;
   pix_type          a_r_ff, a_g_ff, a_b_ff, a_mx_ff;
   logic [SUM_W-1:0] a_sum_ff;
   logic [T1_W-1:0]  a_t1_ff;
   logic [T1_W-1:0]  t3;
   pix_type          mx;

   // divider 1
   logic               d1_v;
   logic [N1_W-1:0]    d1_quo;
   logic [SIDE1_W-1:0] d1_side;
   logic [T1_W-1:0]    d1_t1;
   pix_type            d1_mx, d1_r, d1_g, d1_b;
   logic [SUM_W-1:0]   d1_sum;
   logic [C_W-1:0]     c;
   logic [F+2:0]       c3;

   // stage B
   logic             b_v_ff;
   logic [P_W-1:0]   b_prod_ff;
   logic [T2_W-1:0]  b_t2_ff;
   pix_type          b_r_ff, b_g_ff, b_b_ff, b_mx_ff;
   logic [SUM_W-1:0] b_sum_ff;

   // stage C
   logic             c_v_ff;
   logic [N2_W-1:0]  c_num_ff;
   logic [T1_W-1:0]  c_t0_ff;
   logic             c_pass_ff;
   pix_type          c_r_ff, c_g_ff, c_b_ff;
   logic [SUM_W-1:0] c_sum_ff;
   logic [T1_W-1:0]  t0;
   logic [MT_W-1:0]  mt;

   // divider 2
   logic               d2_v;
   logic [N2_W-1:0]    d2_quo;
   logic [SIDE2_W-1:0] d2_side;
   logic               d2_pass;
   pix_type            d2_r, d2_g, d2_b;
   logic [SUM_W-1:0]   d2_sum;
   logic [N2_W-1:0]    sum_f;
   logic [N2_W-1:0]    mag_full;

   // stage D
   logic             d_v_ff, d_neg_ff, d_pass_ff;
   logic [A_W-1:0]   d_mag_ff;
   pix_type          d_r_ff, d_g_ff, d_b_ff;

   // stage E
   logic               e_v_ff, e_neg_ff, e_pass_ff;
   logic [A_W+K_W-1:0] e_prod_ff;
   pix_type            e_r_ff, e_g_ff, e_b_ff;
   logic [Q_W-1:0]     q3;
   logic signed [SPEC_W-1:0] spec;
   pix_type            fr, fg, fb;

   // output
   logic    out_v_ff;
   pix_type out_r_ff, out_g_ff, out_b_ff;

   assign en        = !out_v_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   always_comb begin
      mx = req_red_in;
      if (req_green_in > mx) mx = req_green_in;
      if (req_blue_in > mx) mx = req_blue_in;
      t3 = T1_W'(req_diffuse_chroma_max) * T1_W'(3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_valid;
         b_v_ff <= d1_v;
         c_v_ff <= b_v_ff;
         d_v_ff <= d2_v;
         e_v_ff <= d_v_ff;
         out_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_r_ff   <= req_red_in;
         a_g_ff   <= req_green_in;
         a_b_ff   <= req_blue_in;
         a_mx_ff  <= mx;
         a_sum_ff <= SUM_W'(req_red_in) + SUM_W'(req_green_in) + SUM_W'(req_blue_in);
         a_t1_ff  <= (t3 > DCM_ONE) ? t3 - DCM_ONE : '0;
      end
   end

   spf_div #(.NUM_W(N1_W), .DEN_W(SUM_W), .SIDE_W(SIDE1_W)) u_div_chroma (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_v_ff),
      .in_num    ({a_mx_ff, F'(0)}),
      .in_den    (a_sum_ff),
      .in_side   ({a_t1_ff, a_mx_ff, a_r_ff, a_g_ff, a_b_ff, a_sum_ff}),
      .out_valid (d1_v),
      .out_quo   (d1_quo),
      .out_side  (d1_side)
   );

   always_comb begin
      {d1_t1, d1_mx, d1_r, d1_g, d1_b, d1_sum} = d1_side;
      c  = d1_quo[C_W-1:0];
      c3 = (F + 3)'(c) * (F + 3)'(3);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_prod_ff <= P_W'(d1_t1) * P_W'(c);
         b_t2_ff   <= (c3 > ONE_F) ? T2_W'(c3 - ONE_F) : '0;
         b_r_ff    <= d1_r;
         b_g_ff    <= d1_g;
         b_b_ff    <= d1_b;
         b_mx_ff   <= d1_mx;
         b_sum_ff  <= d1_sum;
      end
   end

   always_comb begin
      t0 = b_prod_ff[F +: T1_W];
      mt = MT_W'(b_mx_ff) * MT_W'(b_t2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_num_ff  <= {mt, DIFF_SHIFT'(0)};
         c_t0_ff   <= t0;
         c_pass_ff <= (b_sum_ff == '0) || (t0 == '0) || (t0 < T1_W'(thr_ff));
         c_r_ff    <= b_r_ff;
         c_g_ff    <= b_g_ff;
         c_b_ff    <= b_b_ff;
         c_sum_ff  <= b_sum_ff;
      end
   end

   spf_div #(.NUM_W(N2_W), .DEN_W(T1_W), .SIDE_W(SIDE2_W)) u_div_diffuse (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_v_ff),
      .in_num    (c_num_ff),
      .in_den    (c_t0_ff),
      .in_side   ({c_pass_ff, c_r_ff, c_g_ff, c_b_ff, c_sum_ff}),
      .out_valid (d2_v),
      .out_quo   (d2_quo),
      .out_side  (d2_side)
   );

   always_comb begin
      {d2_pass, d2_r, d2_g, d2_b, d2_sum} = d2_side;
      sum_f    = N2_W'(d2_sum) << F;
      mag_full = (d2_quo > sum_f) ? d2_quo - sum_f : sum_f - d2_quo;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_neg_ff  <= d2_quo > sum_f;
         d_mag_ff  <= (mag_full > N2_W'(LIM)) ? LIM : mag_full[A_W-1:0];
         d_pass_ff <= d2_pass;
         d_r_ff    <= d2_r;
         d_g_ff    <= d2_g;
         d_b_ff    <= d2_b;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_prod_ff <= (A_W + K_W)'(d_mag_ff) * (A_W + K_W)'(RECIP);
         e_neg_ff  <= d_neg_ff;
         e_pass_ff <= d_pass_ff;
         e_r_ff    <= d_r_ff;
         e_g_ff    <= d_g_ff;
         e_b_ff    <= d_b_ff;
      end
   end

   always_comb begin
      q3   = e_prod_ff[S_W +: Q_W];
      spec = e_neg_ff ? -$signed(SPEC_W'(q3)) : $signed(SPEC_W'(q3));
   end

   spf_chan #(.FRAC_W(F)) u_chan_r (.ch(e_r_ff), .spec(spec), .ch_out(fr));
   spf_chan #(.FRAC_W(F)) u_chan_g (.ch(e_g_ff), .spec(spec), .ch_out(fg));
   spf_chan #(.FRAC_W(F)) u_chan_b (.ch(e_b_ff), .spec(spec), .ch_out(fb));

   always_ff @(posedge clock) begin
      if (en) begin
         out_r_ff <= e_pass_ff ? e_r_ff : fr;
         out_g_ff <= e_pass_ff ? e_g_ff : fg;
         out_b_ff <= e_pass_ff ? e_b_ff : fb;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_red_out   = out_r_ff;
   assign rsp_green_out = out_g_ff;
   assign rsp_blue_out  = out_b_ff;

endmodule

@@ rtl/spf_check.sv @@
// ----------------------------------------------------------------------------
// spf_check
// Port-level checks for specular_free_pixel, bound to the top level.
// ----------------------------------------------------------------------------
`include "specular_free_pixel_assert.svh"

module spf_check (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input spf_pkg::pix_type rsp_red_out,
   input spf_pkg::pix_type rsp_green_out,
   input spf_pkg::pix_type rsp_blue_out,
   input logic             rsp_valid,
   input logic             rsp_ready
);
   import spf_pkg::*;

   `SPF_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid, "item after reset")
   `SPF_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready, "stall with no item")
   `SPF_ASSERT(a_ready_when_taken, clock, reset, rsp_ready |-> req_ready, "stall while drained")
   `SPF_ASSERT(a_hold_item, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out) && $stable(rsp_green_out)
      && $stable(rsp_blue_out), "stalled item changed")

endmodule

bind specular_free_pixel spf_check u_spf_check (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the specular-free pixel block. A driver streams
// pixels in random bursts, a monitor stalls the result side on its own
// pattern, and a local fixed-point predictor computes each corrected pixel.
// The zero threshold is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
   import spf_pkg::*;

   localparam int FRAC    = 16;
   localparam int LATENCY = 2 * FRAC + 40;

   typedef struct packed {
      pix_type     red;
      pix_type     green;
      pix_type     blue;
      logic [16:0] dcm;
   } pixel_item;

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
   } pixel_result;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [7:0]       req_red_in = '0;
   logic [7:0]       req_green_in = '0;
   logic [7:0]       req_blue_in = '0;
   logic [16:0]      req_diffuse_chroma_max = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_red_out;
   logic [7:0]       rsp_green_out;
   logic [7:0]       rsp_blue_out;
   logic             csr_wr_en = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;

   pixel_item   pending_pixels[$];
   pixel_result expected_pixels[$];
   logic [THR_W-1:0] threshold_model;
   int          error_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_phase = 0;
   bit          stall_on = 1'b0;

   specular_free_pixel #(.CHROMA_FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_red_in(req_red_in), .req_green_in(req_green_in),
      .req_blue_in(req_blue_in), .req_diffuse_chroma_max(req_diffuse_chroma_max),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic pix_type clamp_round(longint ch, longint spec);
      longint v;
      v = (ch <<< FRAC) - spec;
      if (v < 0) v = 0;
      if (v > (longint'(255) <<< FRAC)) v = longint'(255) <<< FRAC;
      return pix_type'((v + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
   endfunction

   function automatic pixel_result remove_specular(pixel_item p);
      pixel_result res;
      longint r, g, b, sum, mx, t1, c, t0, t2, diffuse, spec;
      r = p.red;
      g = p.green;
      b = p.blue;
      sum = r + g + b;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      t1 = 3 * longint'(p.dcm) - 65536;
      res = '{p.red, p.green, p.blue};
      if (t1 > 0 && sum != 0) begin
         c = (mx <<< FRAC) / sum;
         t0 = (t1 * c) >>> FRAC;
         if (t0 != 0 && t0 >= longint'(threshold_model)) begin
            t2 = (3 * c > (longint'(1) <<< FRAC)) ? 3 * c - (longint'(1) <<< FRAC) : 0;
            diffuse = ((mx * t2) <<< 16) / t0;
            spec = ((sum <<< FRAC) - diffuse) / 3;
            res.red = clamp_round(r, spec);
            res.green = clamp_round(g, spec);
            res.blue = clamp_round(b, spec);
         end
      end
      return res;
   endfunction

   task automatic add_pixel(int r, int g, int b, int d);
      pending_pixels.push_back('{pix_type'(r), pix_type'(g), pix_type'(b), 17'(d)});
   endtask

   task automatic add_random_pixels(int n);
      int kind;
      repeat (n) begin
         kind = $urandom_range(0, 9);
         if (kind < 6)
            add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(21846, 65536));
         else if (kind < 8)
            add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 131071));
         else
            add_pixel($urandom_range(0, 40), $urandom_range(0, 40),
                      $urandom_range(0, 40), $urandom_range(0, 131071));
      end
   endtask

   task automatic drain_and_write(logic [THR_W-1:0] value);
      while (pending_pixels.size() != 0 || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      threshold_model = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_pixels.push_back(remove_specular(pending_pixels.pop_front()));
         end
         if (req_valid && !req_ready) begin
            // hold
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() > (req_valid && req_ready ? 0 : 0)
                      && pending_pixels.size() != 0) begin
            req_valid <= 1'b1;
            {req_red_in, req_green_in, req_blue_in, req_diffuse_chroma_max}
               <= pending_pixels[0];
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: stall pattern and compare
   always @(posedge clock) begin
      pixel_result exp_res;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected item %h %h %h", $time,
                        rsp_red_out, rsp_green_out, rsp_blue_out);
               error_count++;
            end else begin
               exp_res = expected_pixels.pop_front();
               if (rsp_red_out !== exp_res.red) begin
                  $display("%0t: red expected %0d actual %0d", $time, exp_res.red, rsp_red_out);
                  error_count++;
               end
               if (rsp_green_out !== exp_res.green) begin
                  $display("%0t: green expected %0d actual %0d", $time,
                           exp_res.green, rsp_green_out);
                  error_count++;
               end
               if (rsp_blue_out !== exp_res.blue) begin
                  $display("%0t: blue expected %0d actual %0d", $time,
                           exp_res.blue, rsp_blue_out);
                  error_count++;
               end
            end
         end
         if (stall_phase == 0) begin
            stall_phase <= $urandom_range(1, 60);
            stall_on <= ($urandom_range(0, 2) == 0);
         end else begin
            stall_phase <= stall_phase - 1;
         end
         rsp_ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   initial begin
      // pending pixel at head is popped on acceptance; a queue head copy
      // is presented, so entries stay until accepted
      threshold_model = THR_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      add_pixel(0, 0, 0, 65536);
      add_pixel(255, 255, 255, 65536);
      add_pixel(255, 0, 0, 65536);
      add_pixel(0, 255, 0, 131071);
      add_pixel(0, 0, 255, 0);
      add_pixel(200, 100, 50, 21845);
      add_pixel(200, 100, 50, 21846);
      add_pixel(200, 100, 50, 30000);
      add_pixel(1, 0, 0, 21846);
      add_pixel(10, 10, 10, 65536);
      add_pixel(170, 85, 0, 43690);
      add_pixel(255, 128, 1, 98304);
      add_pixel(85, 170, 255, 65535);
      add_pixel(0, 1, 0, 131071);
      add_pixel(128, 64, 32, 1);
      add_random_pixels(300);
      drain_and_write(THR_W'(0));
      add_pixel(1, 0, 0, 21846);
      add_pixel(3, 2, 2, 21846);
      add_random_pixels(250);
      drain_and_write({THR_W{1'b1}});
      add_random_pixels(100);
      drain_and_write(THR_W'(20000));
      add_random_pixels(250);
      drain_and_write(THR_W'($urandom_range(0, 262143)));
      add_random_pixels(150);
      while (pending_pixels.size() != 0 || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/spf_pkg.sv
rtl/spf_div.sv
rtl/spf_chan.sv
rtl/specular_free_pixel.sv
rtl/spf_check.sv
tb/tb.sv
